FILE: hdl/ase_pkg.sv
package ase_pkg;

    // sample width taken from the low bits of each axis field
    localparam int SAMPLE_BITS = 16;

    localparam int FIELD_W    = 16;
    localparam int MAG_W      = 15;
    localparam int MPS_W      = 16;
    localparam int KMH_W      = 18;
    localparam int SPEED_W    = 32;
    localparam int THR_W      = 15;
    localparam int COEF_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // square root datapath: radicand is (x*x + y*y) in Q16
    localparam int SQ_W   = 2 * SAMPLE_BITS;
    localparam int RAD_W  = SQ_W + 16;
    localparam int ROOT_W = RAD_W / 2;
    localparam int CNT_W  = $clog2(ROOT_W);

    // shared multiplier
    localparam int GRAV_W  = 20;
    localparam int KMHC_W  = 18;
    localparam int MUL_A_W = (ROOT_W > SPEED_W) ? ROOT_W : SPEED_W;
    localparam int MUL_B_W = (SAMPLE_BITS > GRAV_W) ? SAMPLE_BITS : GRAV_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic [GRAV_W-1:0] GRAVITY_Q16 = GRAV_W'(642908);
    localparam logic [KMHC_W-1:0] KMH_Q16     = KMHC_W'(235930);
    localparam int MAG_SHIFT   = 28;
    localparam int DECAY_SHIFT = 16;
    localparam int KMH_SHIFT   = 32;

    localparam logic [THR_W-1:0]  THR_RST    = THR_W'(179);
    localparam logic [COEF_W-1:0] DECAY_RST  = COEF_W'(45875);
    localparam logic [COEF_W-1:0] PERIOD_RST = COEF_W'(6554);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [SAMPLE_BITS-1:0] amp_t;

    typedef struct packed {
        amp_t ax;
        amp_t ay;
    } sample_t;

    typedef struct packed {
        logic [THR_W-1:0]  thr;
        logic [COEF_W-1:0] decay;
        logic [COEF_W-1:0] period;
    } cfg_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic [MPS_W-1:0] mps;
        logic [KMH_W-1:0] kmh;
    } result_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_DECAY     = 2'd1,
        CFG_PERIOD    = 2'd2
    } cfg_idx_e;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SQX,
        BK_SQY,
        BK_ROOT,
        BK_MAG,
        BK_THRESH,
        BK_SCALE,
        BK_ACC,
        BK_KMH,
        BK_OUT
    } back_state_t;

endpackage

FILE: hdl/ase_if.sv
interface ase_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ase_pkg::FIELD_W-1:0]   accel_x;
    logic signed [ase_pkg::FIELD_W-1:0]   accel_y;

    modport source (output valid, output accel_x, output accel_y, input ready);
    modport sink   (input valid, input accel_x, input accel_y, output ready);
endinterface

interface ase_result_if;
    logic                         valid;
    logic                         ready;
    logic [ase_pkg::MAG_W-1:0]    accel_mag;
    logic [ase_pkg::MPS_W-1:0]    speed_mps;
    logic [ase_pkg::KMH_W-1:0]    speed_kph;

    modport source (output valid, output accel_mag, output speed_mps, output speed_kph,
                    input ready);
    modport sink   (input valid, input accel_mag, input speed_mps, input speed_kph,
                    output ready);
endinterface

interface ase_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ase_pkg::CFG_IDX_W-1:0]    index;
    logic [ase_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/ase_front.sv
module ase_front (
    input  logic                 clk,
    input  logic                 rst_n,
    ase_sample_if.sink           sample,
    output logic                 push,
    output ase_pkg::sample_t     push_data,
    input  logic                 full
);

    logic             hold_valid_reg;
    logic             hold_valid_next;
    ase_pkg::sample_t hold_reg;
    logic             take;

    // |x| of the sign-extended low SAMPLE_BITS bits; the most negative code maps to 2^(N-1)
    function automatic ase_pkg::amp_t abs_sample(logic [ase_pkg::FIELD_W-1:0] f);
        ase_pkg::amp_t raw;
        raw = ase_pkg::SAMPLE_BITS'(f);
        return raw[ase_pkg::SAMPLE_BITS-1] ? (~raw + ase_pkg::amp_t'(1)) : raw;
    endfunction

    assign sample.ready = !hold_valid_reg || !full;
    assign take         = sample.valid && sample.ready;
    assign push         = hold_valid_reg && !full;
    assign push_data    = hold_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_reg.ax <= abs_sample($unsigned(sample.accel_x));
            hold_reg.ay <= abs_sample($unsigned(sample.accel_y));
        end
    end

endmodule

FILE: hdl/ase_queue.sv
module ase_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ase_pkg::sample_t     push_data,
    output logic                 full,
    input  logic                 pop,
    output ase_pkg::sample_t     pop_data,
    output logic                 empty
);

    ase_pkg::sample_t                 entry_reg [ase_pkg::QUEUE_DEPTH];
    logic [ase_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [ase_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [ase_pkg::QCNT_W-1:0]       count_reg, count_next;

    assign full     = (count_reg == ase_pkg::QCNT_W'(ase_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == ase_pkg::QPTR_W'(ase_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == ase_pkg::QPTR_W'(ase_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hdl/ase_back.sv
module ase_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ase_pkg::cfg_t        cfg,
    input  logic                 q_empty,
    input  ase_pkg::sample_t     q_data,
    output logic                 q_pop,
    ase_result_if.source         result
);

    localparam int REM_W  = ase_pkg::ROOT_W + 2;
    localparam int TRY_W  = ase_pkg::ROOT_W + 4;

    ase_pkg::back_state_t state_reg, state_next;

    ase_pkg::amp_t                     ax_reg, ax_next;
    ase_pkg::amp_t                     ay_reg, ay_next;
    logic [ase_pkg::PROD_W-1:0]        mult_reg, mult_next;
    logic [ase_pkg::RAD_W-1:0]         rad_reg, rad_next;
    logic [REM_W-1:0]                  rem_reg, rem_next;
    logic [ase_pkg::ROOT_W-1:0]        root_reg, root_next;
    logic [ase_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic [ase_pkg::MAG_W-1:0]         mag_reg, mag_next;
    logic [ase_pkg::SPEED_W-1:0]       speed_reg, speed_next;
    logic                              out_valid_reg, out_valid_next;
    ase_pkg::result_t                  res_reg, res_next;

    logic [ase_pkg::MUL_A_W-1:0]       mul_a;
    logic [ase_pkg::MUL_B_W-1:0]       mul_b;
    logic [ase_pkg::PROD_W-1:0]        product;
    logic [TRY_W-1:0]                  rem_try;
    logic [TRY_W-1:0]                  trial;
    logic                              root_bit;
    logic [ase_pkg::SQ_W-1:0]          sq_sum;
    logic [ase_pkg::MAG_W-1:0]         mag_sat;
    logic [ase_pkg::SPEED_W:0]         speed_sum;
    logic [ase_pkg::KMH_W-1:0]         kmh_sat;
    logic                              out_free;

    assign product = ase_pkg::PROD_W'(mul_a) * ase_pkg::PROD_W'(mul_b);

    // one radicand digit pair per cycle, restoring form
    assign rem_try  = {rem_reg, rad_reg[ase_pkg::RAD_W-1 -: 2]};
    assign trial    = {2'b00, root_reg, 2'b01};
    assign root_bit = (rem_try >= trial);

    assign sq_sum = mult_reg[ase_pkg::SQ_W-1:0] + product[ase_pkg::SQ_W-1:0];

    assign mag_sat = (|mult_reg[ase_pkg::PROD_W-1:ase_pkg::MAG_SHIFT+ase_pkg::MAG_W]) ?
                     '1 : mult_reg[ase_pkg::MAG_SHIFT +: ase_pkg::MAG_W];

    assign speed_sum = {1'b0, speed_reg} + {1'b0, mult_reg[ase_pkg::SPEED_W-1:0]};

    assign kmh_sat = (|mult_reg[ase_pkg::PROD_W-1:ase_pkg::KMH_SHIFT+ase_pkg::KMH_W]) ?
                     '1 : mult_reg[ase_pkg::KMH_SHIFT +: ase_pkg::KMH_W];

    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next     = state_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        mult_next      = mult_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        cnt_next       = cnt_reg;
        mag_next       = mag_reg;
        speed_next     = speed_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !result.ready;
        q_pop          = 1'b0;
        mul_a          = '0;
        mul_b          = '0;

        case (state_reg)
            ase_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    ax_next    = q_data.ax;
                    ay_next    = q_data.ay;
                    state_next = ase_pkg::BK_SQX;
                end
            end
            ase_pkg::BK_SQX:
            begin
                mul_a      = ase_pkg::MUL_A_W'(ax_reg);
                mul_b      = ase_pkg::MUL_B_W'(ax_reg);
                mult_next  = product;
                state_next = ase_pkg::BK_SQY;
            end
            ase_pkg::BK_SQY:
            begin
                mul_a      = ase_pkg::MUL_A_W'(ay_reg);
                mul_b      = ase_pkg::MUL_B_W'(ay_reg);
                rad_next   = {sq_sum, 16'h0000};
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = ase_pkg::CNT_W'(ase_pkg::ROOT_W - 1);
                state_next = ase_pkg::BK_ROOT;
            end
            ase_pkg::BK_ROOT:
            begin
                rad_next  = rad_reg << 2;
                rem_next  = root_bit ? REM_W'(rem_try - trial) : rem_try[REM_W-1:0];
                root_next = {root_reg[ase_pkg::ROOT_W-2:0], root_bit};
                if (cnt_reg == '0)
                begin
                    state_next = ase_pkg::BK_MAG;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ase_pkg::BK_MAG:
            begin
                mul_a      = ase_pkg::MUL_A_W'(root_reg);
                mul_b      = ase_pkg::MUL_B_W'(ase_pkg::GRAVITY_Q16);
                mult_next  = product;
                state_next = ase_pkg::BK_THRESH;
            end
            ase_pkg::BK_THRESH:
            begin
                mag_next   = (mag_sat < cfg.thr) ? '0 : mag_sat;
                state_next = ase_pkg::BK_SCALE;
            end
            ase_pkg::BK_SCALE:
            begin
                // accelerating: mag * period; idle: speed * decay
                if (mag_reg != '0)
                begin
                    mul_a = ase_pkg::MUL_A_W'(mag_reg);
                    mul_b = ase_pkg::MUL_B_W'(cfg.period);
                end
                else
                begin
                    mul_a = ase_pkg::MUL_A_W'(speed_reg);
                    mul_b = ase_pkg::MUL_B_W'(cfg.decay);
                end
                mult_next  = product;
                state_next = ase_pkg::BK_ACC;
            end
            ase_pkg::BK_ACC:
            begin
                if (mag_reg != '0)
                begin
                    speed_next = speed_sum[ase_pkg::SPEED_W] ? '1 :
                                 speed_sum[ase_pkg::SPEED_W-1:0];
                end
                else
                begin
                    speed_next = mult_reg[ase_pkg::DECAY_SHIFT +: ase_pkg::SPEED_W];
                end
                state_next = ase_pkg::BK_KMH;
            end
            ase_pkg::BK_KMH:
            begin
                mul_a      = ase_pkg::MUL_A_W'(speed_reg);
                mul_b      = ase_pkg::MUL_B_W'(ase_pkg::KMH_Q16);
                mult_next  = product;
                state_next = ase_pkg::BK_OUT;
            end
            ase_pkg::BK_OUT:
            begin
                if (out_free)
                begin
                    res_next.mag   = mag_reg;
                    res_next.mps   = speed_reg[ase_pkg::SPEED_W-1 -: ase_pkg::MPS_W];
                    res_next.kmh   = kmh_sat;
                    out_valid_next = 1'b1;
                    state_next     = ase_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = ase_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ase_pkg::BK_IDLE;
            speed_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            speed_reg     <= speed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        mult_reg <= mult_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
        mag_reg  <= mag_next;
        res_reg  <= res_next;
    end

    assign result.valid     = out_valid_reg;
    assign result.accel_mag = res_reg.mag;
    assign result.speed_mps = res_reg.mps;
    assign result.speed_kph = res_reg.kmh;

endmodule

FILE: hdl/accel_speed_estimator_core.sv
// Speed estimator: each accepted word is one X/Y accelerometer sample and yields exactly one
// result word (thresholded horizontal magnitude, speed in m/s and km/h, 1/256 units). From the
// head of the queue to the output register a sample goes through the bit-pair-per-cycle square
// root and single steps, the multiplying ones sharing one multiplier; the datapath takes the
// next sample only once the last result has gone into the output register.
// Up to three samples can sit in the input stage and queue while the datapath runs, and a
// finished result waits in its own register. Configuration writes are always accepted and take
// effect at once, so write them only while no sample is in flight.
module accel_speed_estimator_core (
    input  logic          clk,
    input  logic          rst_n,
    ase_sample_if.sink    sample,
    ase_result_if.source  result,
    ase_cfg_if.sink       cfg
);

    ase_pkg::cfg_t    cfg_reg, cfg_next;
    logic             push;
    ase_pkg::sample_t push_data;
    logic             full;
    logic             pop;
    ase_pkg::sample_t pop_data;
    logic             empty;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                ase_pkg::CFG_THRESHOLD: cfg_next.thr    = cfg.data[ase_pkg::THR_W-1:0];
                ase_pkg::CFG_DECAY:     cfg_next.decay  = cfg.data[ase_pkg::COEF_W-1:0];
                ase_pkg::CFG_PERIOD:    cfg_next.period = cfg.data[ase_pkg::COEF_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.thr    <= ase_pkg::THR_RST;
            cfg_reg.decay  <= ase_pkg::DECAY_RST;
            cfg_reg.period <= ase_pkg::PERIOD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ase_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    ase_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    ase_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (empty),
        .q_data  (pop_data),
        .q_pop   (pop),
        .result  (result)
    );

endmodule

FILE: hdl/ase_checker.sv
module ase_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic                       r_valid,
    input  logic                       r_ready,
    input  logic [ase_pkg::MAG_W-1:0]  r_mag,
    input  logic [ase_pkg::MPS_W-1:0]  r_mps,
    input  logic [ase_pkg::KMH_W-1:0]  r_kmh
);

    logic [2:0]                  inflight_reg, inflight_next;
    logic [ase_pkg::MPS_W-1:0]   prev_mps_reg, prev_mps_next;
    logic                        s_take;
    logic                        r_take;
    logic [19:0]                 mps_x3;
    logic [19:0]                 mps_x4;
    logic [19:0]                 kmh_ext;

    assign s_take  = s_valid && s_ready;
    assign r_take  = r_valid && r_ready;
    assign mps_x3  = 20'(r_mps) * 20'd3;
    assign mps_x4  = 20'(r_mps) * 20'd4 + 20'd4;
    assign kmh_ext = 20'(r_kmh);

    always_comb
    begin
        inflight_next = inflight_reg;
        case ({s_take, r_take})
            2'b10:   inflight_next = inflight_reg + 1'b1;
            2'b01:   inflight_next = inflight_reg - 1'b1;
            default: inflight_next = inflight_reg;
        endcase
        prev_mps_next = r_take ? r_mps : prev_mps_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
            prev_mps_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
            prev_mps_reg <= prev_mps_next;
        end
    end

    // no result word without a sample word still outstanding
    a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
        r_take |-> (inflight_reg != 3'd0))
        else $error("result word with no sample outstanding");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid)
        else $error("result valid dropped while stalled");

    // km/h lies between 3x and 4x m/s (plus 4), a loose bound around the 3.6x ratio
    a_kmh_tracks_mps: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid |-> (kmh_ext >= mps_x3) && (kmh_ext <= mps_x4))
        else $error("km/h output inconsistent with m/s output");

    // with no acceleration the speed can only decay
    a_decay_no_rise: assert property (@(posedge clk) disable iff (!rst_n)
        r_take && (r_mag == '0) |-> (r_mps <= prev_mps_reg))
        else $error("speed rose with zero acceleration");

endmodule

bind accel_speed_estimator_core ase_checker u_ase_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (sample.valid),
    .s_ready (sample.ready),
    .r_valid (result.valid),
    .r_ready (result.ready),
    .r_mag   (result.accel_mag),
    .r_mps   (result.speed_mps),
    .r_kmh   (result.speed_kph)
);

FILE: tb/sv/speed_estimate_checker.sv
module speed_estimate_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                smp_valid,
    input  logic                                smp_ready,
    input  logic signed [ase_pkg::FIELD_W-1:0]  smp_x,
    input  logic signed [ase_pkg::FIELD_W-1:0]  smp_y,
    input  logic                                res_valid,
    input  logic                                res_ready,
    input  logic [ase_pkg::MAG_W-1:0]           res_mag,
    input  logic [ase_pkg::MPS_W-1:0]           res_mps,
    input  logic [ase_pkg::KMH_W-1:0]           res_kmh,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [ase_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ase_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                  outstanding,
    output int                                  errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned MAG_MAX   = (64'd1 << ase_pkg::MAG_W) - 1;
    localparam longint unsigned KMH_MAX   = (64'd1 << ase_pkg::KMH_W) - 1;
    localparam longint unsigned SPEED_MAX = (64'd1 << ase_pkg::SPEED_W) - 1;

    ase_pkg::cfg_t               regs;
    logic [ase_pkg::SPEED_W-1:0] speed_q24;
    ase_pkg::result_t            expected_results[$];

    // one sample -> thresholded magnitude, updated speed, speed in m/s and km/h
    function automatic ase_pkg::result_t predict_speed(
        input  logic signed [ase_pkg::FIELD_W-1:0] x,
        input  logic signed [ase_pkg::FIELD_W-1:0] y,
        input  ase_pkg::cfg_t                      rc,
        input  logic [ase_pkg::SPEED_W-1:0]        speed_in,
        output logic [ase_pkg::SPEED_W-1:0]        speed_out
    );
        longint           sx;
        longint           sy;
        longint unsigned  rad;
        longint unsigned  root;
        longint unsigned  cand;
        longint unsigned  mag;
        longint unsigned  sum;
        longint unsigned  kmh;
        ase_pkg::result_t res;

        sx = x;
        sy = y;
        if (sx < 0)
            sx = -sx;
        if (sy < 0)
            sy = -sy;
        rad = sx * sx + sy * sy;
        rad = rad << 16;

        // floor sqrt, one bit at a time from the top
        root = 0;
        for (int b = ase_pkg::ROOT_W; b >= 0; b--)
        begin
            cand = root | (64'd1 << b);
            if (cand * cand <= rad)
                root = cand;
        end

        mag = (root * ase_pkg::GRAVITY_Q16) >> ase_pkg::MAG_SHIFT;
        if (mag > MAG_MAX)
            mag = MAG_MAX;
        if (mag < rc.thr)
            mag = 0;

        if (mag != 0)
        begin
            sum = speed_in + mag * rc.period;
            speed_out = (sum > SPEED_MAX) ? '1 : ase_pkg::SPEED_W'(sum);
        end
        else
            speed_out = ase_pkg::SPEED_W'((64'(speed_in) * rc.decay) >> ase_pkg::DECAY_SHIFT);

        kmh = (64'(speed_out) * ase_pkg::KMH_Q16) >> ase_pkg::KMH_SHIFT;
        if (kmh > KMH_MAX)
            kmh = KMH_MAX;

        res.mag = ase_pkg::MAG_W'(mag);
        res.mps = speed_out[ase_pkg::SPEED_W-1 -: ase_pkg::MPS_W];
        res.kmh = ase_pkg::KMH_W'(kmh);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ase_pkg::result_t            want;
        ase_pkg::result_t            got;
        logic [ase_pkg::SPEED_W-1:0] next_speed;

        if (!rst_n)
        begin
            regs.thr    = ase_pkg::THR_RST;
            regs.decay  = ase_pkg::DECAY_RST;
            regs.period = ase_pkg::PERIOD_RST;
            speed_q24   = '0;
            expected_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ase_pkg::CFG_THRESHOLD: regs.thr    = cfg_data[ase_pkg::THR_W-1:0];
                    ase_pkg::CFG_DECAY:     regs.decay  = cfg_data[ase_pkg::COEF_W-1:0];
                    ase_pkg::CFG_PERIOD:    regs.period = cfg_data[ase_pkg::COEF_W-1:0];
                    default:                ;
                endcase
            end

            // result is checked before this edge's sample is queued
            if (res_valid && res_ready)
            begin
                got.mag = res_mag;
                got.mps = res_mps;
                got.kmh = res_kmh;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result word with nothing expected: mag %0d mps %0d kmh %0d",
                             $time, got.mag, got.mps, got.kmh);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.mag !== want.mag)
                    begin
                        errors++;
                        $display("%0t: accel_mag expected %0d, actual %0d",
                                 $time, want.mag, got.mag);
                    end
                    if (got.mps !== want.mps)
                    begin
                        errors++;
                        $display("%0t: speed_mps expected %0d, actual %0d",
                                 $time, want.mps, got.mps);
                    end
                    if (got.kmh !== want.kmh)
                    begin
                        errors++;
                        $display("%0t: speed_kph expected %0d, actual %0d",
                                 $time, want.kmh, got.kmh);
                    end
                end
            end

            if (smp_valid && smp_ready)
            begin
                want = predict_speed(smp_x, smp_y, regs, speed_q24, next_speed);
                speed_q24 = next_speed;
                expected_results.push_back(want);
            end

            outstanding <= expected_results.size();
        end
    end

endmodule

FILE: tb/sv/accel_speed_estimator_core_tb.sv
module accel_speed_estimator_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 95;
    localparam int TAIL_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 4000;

    // index with no register behind it
    localparam logic [ase_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    int pending_results;
    int mismatch_count;
    int src_gap_pct;
    int snk_stall_pct;
    int idle_cycles;

    ase_sample_if sample_ch();
    ase_result_if result_ch();
    ase_cfg_if    cfg_ch();

    accel_speed_estimator_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    speed_estimate_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .smp_valid   (sample_ch.valid),
        .smp_ready   (sample_ch.ready),
        .smp_x       (sample_ch.accel_x),
        .smp_y       (sample_ch.accel_y),
        .res_valid   (result_ch.valid),
        .res_ready   (result_ch.ready),
        .res_mag     (result_ch.accel_mag),
        .res_mps     (result_ch.speed_mps),
        .res_kmh     (result_ch.speed_kph),
        .cfg_valid   (cfg_ch.valid),
        .cfg_ready   (cfg_ch.ready),
        .cfg_index   (cfg_ch.index),
        .cfg_data    (cfg_ch.data),
        .outstanding (pending_results),
        .errors      (mismatch_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_sample(input logic signed [ase_pkg::FIELD_W-1:0] x,
                               input logic signed [ase_pkg::FIELD_W-1:0] y);
        cfg_ch.valid <= 1'b0;
        if (src_gap_pct != 0 && $urandom_range(1, 100) <= src_gap_pct)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        sample_ch.valid   <= 1'b1;
        sample_ch.accel_x <= x;
        sample_ch.accel_y <= y;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
    endtask

    // leaves valid high so back-to-back writes need no toggle
    task automatic write_reg(input logic [ase_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ase_pkg::CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [ase_pkg::FIELD_W-1:0] edge_sample();
        case ($urandom_range(0, 5))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return 16'sd0;
            3:       return -16'sd1;
            4:       return 16'sd1;
            default: return ase_pkg::FIELD_W'($urandom);
        endcase
    endfunction

    // result side back-pressure
    initial
    begin
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (snk_stall_pct != 0 && $urandom_range(1, 100) <= snk_stall_pct)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic signed [ase_pkg::FIELD_W-1:0] x;
        logic signed [ase_pkg::FIELD_W-1:0] y;
        logic [ase_pkg::CFG_DATA_W-1:0]     value;
        int                                 seg_kind;
        int                                 seg_left;

        rst_n             <= 1'b0;
        sample_ch.valid   <= 1'b0;
        sample_ch.accel_x <= '0;
        sample_ch.accel_y <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= ase_pkg::CFG_THRESHOLD;
        cfg_ch.data       <= '0;
        src_gap_pct   = 20;
        snk_stall_pct = 20;
        idle_cycles   = 0;
        seg_kind      = 0;
        seg_left      = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: extremes, 1 G on each axis, samples around the threshold
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd32767, 16'sd32767);
        send_sample(-16'sd32768, -16'sd32768);
        send_sample(-16'sd32768, 16'sd32767);
        send_sample(16'sd32767, -16'sd32768);
        send_sample(16'sd4096, 16'sd0);
        send_sample(16'sd0, -16'sd4096);
        send_sample(16'sd1, -16'sd1);
        send_sample(16'sd292, 16'sd0);
        send_sample(16'sd293, 16'sd0);
        send_sample(16'sd0, -16'sd291);
        send_sample(-16'sd1, -16'sd1);

        // zero threshold, longest period, largest decay coefficient: overflow and hold at max
        drain_results();
        write_reg(ase_pkg::CFG_THRESHOLD, 16'd0);
        write_reg(ase_pkg::CFG_PERIOD, 16'hFFFF);
        write_reg(ase_pkg::CFG_DECAY, 16'hFFFF);
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd1, 16'sd0);
        send_sample(16'sd2, 16'sd0);
        repeat (4)
            send_sample(-16'sd32768, -16'sd32768);
        send_sample(16'sd0, 16'sd0);

        // oversized threshold write keeps low bits only; unmapped index is dropped
        drain_results();
        write_reg(ase_pkg::CFG_THRESHOLD, 16'hFFFF);
        write_reg(ase_pkg::CFG_DECAY, 16'd0);
        write_reg(CFG_UNUSED, 16'h0001);
        send_sample(16'sd32767, 16'sd32767);
        send_sample(-16'sd32768, 16'sd0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_results();

            if (ph == 0 || $urandom_range(0, 1))
            begin
                case ($urandom_range(0, 3))
                    0:       value = 16'd0;
                    1:       value = 16'hFFFF;
                    2:       value = ase_pkg::CFG_DATA_W'($urandom_range(0, 2000));
                    default: value = ase_pkg::CFG_DATA_W'($urandom);
                endcase
                write_reg(ase_pkg::CFG_THRESHOLD, value);
            end
            if (ph == 0 || $urandom_range(0, 1))
            begin
                case ($urandom_range(0, 3))
                    0:       value = 16'd0;
                    1:       value = 16'hFFFF;
                    2:       value = ase_pkg::DECAY_RST;
                    default: value = ase_pkg::CFG_DATA_W'($urandom);
                endcase
                write_reg(ase_pkg::CFG_DECAY, value);
            end
            if (ph == 0 || $urandom_range(0, 1))
            begin
                case ($urandom_range(0, 3))
                    0:       value = 16'd0;
                    1:       value = 16'hFFFF;
                    2:       value = ase_pkg::CFG_DATA_W'($urandom_range(0, 8000));
                    default: value = ase_pkg::CFG_DATA_W'($urandom);
                endcase
                write_reg(ase_pkg::CFG_PERIOD, value);
            end
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_UNUSED, ase_pkg::CFG_DATA_W'($urandom));

            if (ph == PHASES - 1)
            begin
                src_gap_pct   = 0;
                snk_stall_pct = 0;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        src_gap_pct   = 0;
                        snk_stall_pct = 0;
                    end
                    1:
                    begin
                        src_gap_pct   = 30;
                        snk_stall_pct = 0;
                    end
                    2:
                    begin
                        src_gap_pct   = 0;
                        snk_stall_pct = 30;
                    end
                    default:
                    begin
                        src_gap_pct   = $urandom_range(5, 50);
                        snk_stall_pct = $urandom_range(5, 50);
                    end
                endcase
            end

            // runs of driving, coasting, near-threshold jitter, edge values and raw noise
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (seg_left == 0)
                begin
                    seg_kind = $urandom_range(0, 4);
                    seg_left = $urandom_range(1, 20);
                end
                seg_left--;
                case (seg_kind)
                    0:
                    begin
                        x = ase_pkg::FIELD_W'(int'($urandom_range(300, 8000)) *
                                              ($urandom_range(0, 1) ? 1 : -1));
                        y = ase_pkg::FIELD_W'(int'($urandom_range(0, 8000)) - 4000);
                    end
                    1:
                    begin
                        x = ase_pkg::FIELD_W'(int'($urandom_range(0, 6)) - 3);
                        y = ase_pkg::FIELD_W'(int'($urandom_range(0, 6)) - 3);
                    end
                    2:
                    begin
                        x = ase_pkg::FIELD_W'(int'($urandom_range(0, 800)) - 400);
                        y = ase_pkg::FIELD_W'(int'($urandom_range(0, 800)) - 400);
                    end
                    3:
                    begin
                        x = edge_sample();
                        y = edge_sample();
                    end
                    default:
                    begin
                        x = ase_pkg::FIELD_W'($urandom);
                        y = ase_pkg::FIELD_W'($urandom);
                    end
                endcase
                send_sample(x, y);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
